>>> design/conflict_serializability_checker_defines.svh
// Assertion macros for the conflict serializability checker.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CONFLICT_SERIALIZABILITY_CHECKER_DEFINES_SVH
`define CONFLICT_SERIALIZABILITY_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT_HOLD(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("check failed");
`define CSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CSC_ASSERT_HOLD(label, clk, rst, cond)
`define CSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/csc_pkg.sv
// Shared constants for the conflict serializability checker.
// No dependencies.
`timescale 1ns / 1ps
package csc_pkg;
  localparam int CSC_MAX_TXN  = 16;
  localparam int CSC_MAX_DATA = 64;
  localparam int TXN_W        = 4;
  localparam int DATA_W       = 6;
  localparam int NUM_TXN_W    = 5;
  localparam logic [NUM_TXN_W-1:0] NUM_TXN_RESET = 5'd16;
  localparam int APB_ADDR_W   = 2;
  localparam int APB_DATA_W   = 32;
  localparam logic [APB_ADDR_W-1:0] REG_NUM_TXN = 2'd0;
endpackage

>>> design/conflict_serializability_checker.sv
// Conflict serializability checker: precedence graph build and cycle search.
// Depends on csc_pkg and conflict_serializability_checker_defines.svh.
//
// Usage:
//   Operations arrive on the command channel: an operation transfers at a
//   rising edge with start high and busy low. Each operation is accepted,
//   then does one read-modify-write of the item's reader/writer sets
//   and the adjacency rows, over the set memory's read and write ports.
//   An operation with last_op set then runs a depth-first search, one stack
//   push or pop per cycle.
//   Results follow one per cycle with valid high for exactly one cycle each:
//   either n transactions in reverse postorder with serializable high, or a
//   single result with serializable low and order_txn zero. last_result marks
//   the final result. After that the graph and sets are dropped and a new
//   schedule begins. The receiver cannot stall; results are not held.
//   Configuration: APB register num_txn at byte address 0; write while idle.
//   Reset (rst, synchronous): sets and graph empty, num_txn = 16, idle.
`timescale 1ns / 1ps
`include "conflict_serializability_checker_defines.svh"
module conflict_serializability_checker #(
  parameter int MAX_TXN  = csc_pkg::CSC_MAX_TXN,
  parameter int MAX_DATA = csc_pkg::CSC_MAX_DATA
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [csc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [csc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [csc_pkg::TXN_W-1:0]         txn_id,
  input  logic [csc_pkg::DATA_W-1:0]        data_id,
  input  logic                              is_write,
  input  logic                              last_op,
  output logic                              valid,
  output logic                              serializable,
  output logic [csc_pkg::TXN_W-1:0]         order_txn,
  output logic                              last_result
);
  import csc_pkg::*;

  localparam int TW = $clog2(MAX_TXN);
  localparam int NW = $clog2(MAX_TXN + 1);
  localparam int DW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FAIL = 3'd5;

  logic [2:0] state;
  logic [NUM_TXN_W-1:0] num_txn;

  // Configuration port: single register, always ready.
  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(num_txn);
  always_ff @(posedge clk) begin
    if (rst) begin
      num_txn <= NUM_TXN_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_NUM_TXN)) begin
      num_txn <= pwdata[NUM_TXN_W-1:0];
    end
  end

  // Effective transaction count, clamped to 1..MAX_TXN.
  logic [6:0] n7;
  logic [NW-1:0] n;
  always_comb begin
    n7 = 7'(num_txn);
    if (n7 == 7'd0) n7 = 7'd1;
    else if (n7 > 7'(MAX_TXN)) n7 = 7'(MAX_TXN);
  end
  assign n = n7[NW-1:0];

  logic [MAX_TXN-1:0] inrange;
  always_comb begin
    for (int i = 0; i < MAX_TXN; i++) inrange[i] = (7'(i) < n7);
  end

  // Reader/writer set memory, {writers, readers} per item, plus valid bits.
  logic [2*MAX_TXN-1:0] sets_mem [MAX_DATA];
  logic [MAX_DATA-1:0]  set_ok;
  logic [2*MAX_TXN-1:0] sets_rd;
  logic                 set_ok_rd;
  logic [10:0]          d_wide;
  logic [DW-1:0]        d_addr;
  assign d_wide = 11'(data_id);
  assign d_addr = d_wide[DW-1:0];

  always_ff @(posedge clk) begin
    sets_rd   <= sets_mem[d_addr];
    set_ok_rd <= set_ok[d_addr];
  end

  // Captured operation.
  logic [DW-1:0]      op_addr;
  logic [MAX_TXN-1:0] op_me;
  logic               op_write;
  logic               op_last;
  logic               op_ok;

  logic [MAX_TXN-1:0] adj [MAX_TXN];
  logic [MAX_TXN-1:0] visited, on_path;
  logic [TW-1:0]      stack [MAX_TXN];
  logic [TW-1:0]      order_buf [MAX_TXN];
  logic [NW-1:0]      depth, posted, root, k;

  // Load step datapath.
  logic [MAX_TXN-1:0] rd_set, wr_set, src;
  logic [2*MAX_TXN-1:0] sets_wr;
  always_comb begin
    rd_set = set_ok_rd ? sets_rd[MAX_TXN-1:0] : '0;
    wr_set = set_ok_rd ? sets_rd[2*MAX_TXN-1:MAX_TXN] : '0;
    src    = (op_write ? (rd_set | wr_set) : wr_set) & ~op_me;
    sets_wr = op_write ? {wr_set | op_me, rd_set} : {wr_set, rd_set | op_me};
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && op_ok) sets_mem[op_addr] <= sets_wr;
  end

  // Search step datapath.
  logic [NW-1:0]      dm1;
  logic [TW-1:0]      v;
  logic [MAX_TXN-1:0] succ, fresh;
  logic [TW-1:0]      first;
  always_comb begin
    dm1   = depth - NW'(1);
    v     = stack[dm1[TW-1:0]];
    succ  = adj[v] & inrange;
    fresh = succ & ~visited;
    first = '0;
    for (int i = MAX_TXN - 1; i >= 0; i--) begin
      if (fresh[i]) first = TW'(i);
    end
  end

  logic [NW-1:0] emit_idx;
  logic [TW+3:0] emit_wide;
  assign emit_idx  = n - NW'(1) - k;
  assign emit_wide = (TW + 4)'(order_buf[emit_idx[TW-1:0]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      set_ok  <= '0;
      for (int i = 0; i < MAX_TXN; i++) adj[i] <= '0;
      visited <= '0;
      on_path <= '0;
      depth   <= '0;
      posted  <= '0;
      root    <= '0;
      k       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_addr  <= d_addr;
            op_me    <= MAX_TXN'(1) << txn_id;
            op_write <= is_write;
            op_last  <= last_op;
            op_ok    <= (7'(txn_id) < n7) && (d_wide < 11'(MAX_DATA));
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (op_ok) begin
            set_ok[op_addr] <= 1'b1;
            for (int i = 0; i < MAX_TXN; i++) begin
              if (src[i]) adj[i] <= adj[i] | op_me;
            end
          end
          visited <= '0;
          on_path <= '0;
          depth   <= '0;
          posted  <= '0;
          root    <= '0;
          k       <= '0;
          state   <= op_last ? S_ROOT : S_IDLE;
        end
        S_ROOT: begin
          if (root == n) begin
            state <= S_EMIT;
          end else if (visited[root[TW-1:0]]) begin
            root <= root + NW'(1);
          end else begin
            visited[root[TW-1:0]] <= 1'b1;
            on_path[root[TW-1:0]] <= 1'b1;
            stack[0] <= root[TW-1:0];
            depth    <= NW'(1);
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          if ((succ & on_path) != '0) begin
            state <= S_FAIL;
          end else if (fresh != '0 && depth < NW'(MAX_TXN)) begin
            visited[first] <= 1'b1;
            on_path[first] <= 1'b1;
            stack[depth[TW-1:0]] <= first;
            depth <= depth + NW'(1);
          end else begin
            on_path[v] <= 1'b0;
            if (posted < NW'(MAX_TXN)) begin
              order_buf[posted[TW-1:0]] <= v;
              posted <= posted + NW'(1);
            end
            depth <= dm1;
            if (depth == NW'(1)) begin
              root  <= root + NW'(1);
              state <= S_ROOT;
            end
          end
        end
        S_EMIT: begin
          k <= k + NW'(1);
          if (k + NW'(1) == n) begin
            set_ok <= '0;
            for (int i = 0; i < MAX_TXN; i++) adj[i] <= '0;
            state <= S_IDLE;
          end
        end
        S_FAIL: begin
          set_ok <= '0;
          for (int i = 0; i < MAX_TXN; i++) adj[i] <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign valid        = (state == S_EMIT) || (state == S_FAIL);
  assign serializable = (state == S_EMIT);
  assign order_txn    = (state == S_EMIT) ? emit_wide[3:0] : '0;
  assign last_result  = (state == S_FAIL) || ((state == S_EMIT) && (k + NW'(1) == n));

  `CSC_ASSERT_IMPL(a_fail_is_last, clk, rst, valid && !serializable, last_result)
  `CSC_ASSERT_HOLD(a_depth_bound, clk, rst, depth <= NW'(MAX_TXN))
  `CSC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CSC_ASSERT_IMPL(a_walk_depth, clk, rst, state == S_WALK, depth != '0)
endmodule
